[hdl/eiphp_pkg.sv]
// ----------------------------------------------------------------------------
// eiphp_pkg
// shared types and constants for the ethernet / ipv4 header parser
// ----------------------------------------------------------------------------
package eiphp_pkg;

    localparam int LEN_W      = 16;                  // frame length counter width
    localparam int CRC_BYTES  = 4;                   // trailing fcs bytes
    localparam int CRC_W      = 8 * CRC_BYTES;
    localparam int CRC_IDX_W  = $clog2(CRC_BYTES);
    localparam int VAL_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [LEN_W-1:0] LEN_MAX      = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] ETH_HDR_BASE = LEN_W'(14);
    localparam logic [LEN_W-1:0] ETH_HDR_VLAN = LEN_W'(18);
    localparam logic [LEN_W-1:0] IP_HDR_MIN   = LEN_W'(20);
    localparam logic [15:0]      ETYPE_VLAN   = 16'h8100;
    localparam logic [7:0]       VER_MASK     = 8'hF0;
    localparam logic [7:0]       VER_IPV4     = 8'h40;
    localparam logic [12:0]      FRAG_MASK    = 13'h1FFF;

    localparam logic [CFG_W-1:0] MIN_LEN_RST  = CFG_W'(64);
    localparam logic [CFG_W-1:0] MAX_LEN_RST  = CFG_W'(1522);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_FRAME_LEN = 2'd0,
        REG_MAX_FRAME_LEN = 2'd1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        FC_DST       = 5'd0,
        FC_SRC       = 5'd1,
        FC_TYPE      = 5'd2,
        FC_VLAN      = 5'd3,
        FC_DSCP      = 5'd4,
        FC_ID        = 5'd5,
        FC_FLAGS     = 5'd6,
        FC_FRAGOFF   = 5'd7,
        FC_TTL       = 5'd8,
        FC_PROTO     = 5'd9,
        FC_CKSUM     = 5'd10,
        FC_IPSRC     = 5'd11,
        FC_IPDST     = 5'd12,
        FC_OPTION    = 5'd13,
        FC_IPPAYLOAD = 5'd14,
        FC_OTHER     = 5'd15,
        FC_CRC       = 5'd16,
        FC_STATUS    = 5'd17
    } field_code_t;

    typedef enum logic [2:0] {
        ST_IPV4_OK  = 3'd0,
        ST_NONIP_OK = 3'd1,
        ST_SHORT    = 3'd2,
        ST_LONG     = 3'd3,
        ST_BADLEN   = 3'd4,
        ST_TRUNC    = 3'd5
    } frame_status_t;

    // one classified request: a parsed field (two for flags/fragoff) and,
    // at frame end, the fcs and the status
    typedef struct packed {
        logic             parse_valid;
        logic             parse_split;
        field_code_t      parse_code;
        logic [VAL_W-1:0] parse_val;
        logic             frame_end;
        logic [CRC_W-1:0] crc;
        frame_status_t    status;
    } fr_entry_t;

endpackage

[hdl/eiphp_front.sv]
// ----------------------------------------------------------------------------
// eiphp_front
// accepts frame bytes, runs the fcs delay line and classifies each byte
// ----------------------------------------------------------------------------
module eiphp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [eiphp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eiphp_pkg::CFG_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_frame_end,
    input  logic                          q_full,
    output logic                          push,
    output eiphp_pkg::fr_entry_t          push_entry
);
    import eiphp_pkg::*;

    logic [CFG_W-1:0]     min_len_reg;
    logic [CFG_W-1:0]     max_len_reg;
    logic [LEN_W-1:0]     byte_count_reg, byte_count_next;
    logic [VAL_W-1:0]     acc_reg, acc_next;
    logic                 has_vlan_reg, has_vlan_next;
    logic                 is_ipv4_reg, is_ipv4_next;
    logic [3:0]           header_words_reg, header_words_next;
    logic [LEN_W-1:0]     ip_total_len_reg, ip_total_len_next;
    logic [1:0]           sticky_reg, sticky_next;
    logic [7:0]           delay_reg [CRC_BYTES];
    logic [7:0]           delay_next [CRC_BYTES];

    logic                 accept;
    logic [LEN_W-1:0]     p, q, hdr, hl;
    logic [LEN_W-1:0]     hdr_pp, hl_pp, pl, fill;
    logic [7:0]           old_byte;
    logic [VAL_W-1:0]     acc_shift;
    logic                 vlan_pp, ipv4_pp;
    logic [3:0]           hw_pp;
    logic [LEN_W-1:0]     iptl_pp, bc_pp;
    logic [1:0]           sticky_pp;
    logic [CRC_W-1:0]     crc;
    frame_status_t        status;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign p         = byte_count_reg - LEN_W'(CRC_BYTES);
    assign hdr       = has_vlan_reg ? ETH_HDR_VLAN : ETH_HDR_BASE;
    assign q         = p - hdr;
    assign hl        = (header_words_reg < 4'd5) ? IP_HDR_MIN
                                                 : LEN_W'({header_words_reg, 2'b00});
    assign old_byte  = delay_reg[0];
    assign acc_shift = {acc_reg[VAL_W-9:0], old_byte};

    always_comb begin
        push_entry             = '0;
        push_entry.parse_code  = FC_DST;
        push_entry.parse_val   = acc_shift;
        push_entry.status      = ST_IPV4_OK;
        acc_next               = acc_reg;
        vlan_pp                = has_vlan_reg;
        ipv4_pp                = is_ipv4_reg;
        hw_pp                  = header_words_reg;
        iptl_pp                = ip_total_len_reg;
        sticky_pp              = sticky_reg;
        delay_next             = delay_reg;
        bc_pp                  = byte_count_reg;

        // parse the byte leaving the delay line
        if (byte_count_reg >= LEN_W'(CRC_BYTES)) begin
            acc_next = acc_shift;
            if (p < ETH_HDR_BASE) begin
                if (p == LEN_W'(5)) begin
                    push_entry.parse_valid = 1'b1;
                    push_entry.parse_code  = FC_DST;
                end else if (p == LEN_W'(11)) begin
                    push_entry.parse_valid = 1'b1;
                    push_entry.parse_code  = FC_SRC;
                end else if (p == LEN_W'(13)) begin
                    vlan_pp                = (acc_shift[15:0] == ETYPE_VLAN);
                    push_entry.parse_valid = 1'b1;
                    push_entry.parse_code  = FC_TYPE;
                    push_entry.parse_val   = VAL_W'(acc_shift[15:0]);
                end
            end else if (p < hdr) begin
                if (p == LEN_W'(17)) begin
                    push_entry.parse_valid = 1'b1;
                    push_entry.parse_code  = FC_VLAN;
                    push_entry.parse_val   = VAL_W'(acc_shift[31:0]);
                end
            end else if (q == '0) begin
                // version / ihl byte
                ipv4_pp = ((old_byte & VER_MASK) == VER_IPV4);
                hw_pp   = old_byte[3:0];
                if (!ipv4_pp) begin
                    push_entry.parse_valid = 1'b1;
                    push_entry.parse_code  = FC_OTHER;
                    push_entry.parse_val   = VAL_W'(old_byte);
                end else if (old_byte[3:0] < 4'd5) begin
                    sticky_pp[1] = 1'b1;
                end
            end else if (!is_ipv4_reg) begin
                push_entry.parse_valid = 1'b1;
                push_entry.parse_code  = FC_OTHER;
                push_entry.parse_val   = VAL_W'(old_byte);
            end else if (q < IP_HDR_MIN) begin
                push_entry.parse_valid = 1'b1;
                case (q[4:0])
                    5'd1: begin
                        push_entry.parse_code = FC_DSCP;
                        push_entry.parse_val  = VAL_W'(old_byte);
                    end
                    5'd3: begin
                        push_entry.parse_valid = 1'b0;
                        iptl_pp                = LEN_W'(acc_shift[15:0]);
                        if (LEN_W'(acc_shift[15:0]) < hl) begin
                            sticky_pp[1] = 1'b1;
                        end
                    end
                    5'd5: begin
                        push_entry.parse_code = FC_ID;
                        push_entry.parse_val  = VAL_W'(acc_shift[15:0]);
                    end
                    5'd7: begin
                        // flags and fragment offset go out as two results
                        push_entry.parse_code  = FC_FLAGS;
                        push_entry.parse_split = 1'b1;
                        push_entry.parse_val   = VAL_W'(acc_shift[15:0]);
                    end
                    5'd8: begin
                        push_entry.parse_code = FC_TTL;
                        push_entry.parse_val  = VAL_W'(old_byte);
                    end
                    5'd9: begin
                        push_entry.parse_code = FC_PROTO;
                        push_entry.parse_val  = VAL_W'(old_byte);
                    end
                    5'd11: begin
                        push_entry.parse_code = FC_CKSUM;
                        push_entry.parse_val  = VAL_W'(acc_shift[15:0]);
                    end
                    5'd15: begin
                        push_entry.parse_code = FC_IPSRC;
                        push_entry.parse_val  = VAL_W'(acc_shift[31:0]);
                    end
                    5'd19: begin
                        push_entry.parse_code = FC_IPDST;
                        push_entry.parse_val  = VAL_W'(acc_shift[31:0]);
                    end
                    default: begin
                        push_entry.parse_valid = 1'b0;
                    end
                endcase
            end else if (q < hl) begin
                if (q[1:0] == 2'b11) begin
                    push_entry.parse_valid = 1'b1;
                    push_entry.parse_code  = FC_OPTION;
                    push_entry.parse_val   = VAL_W'(acc_shift[31:0]);
                end
            end else begin
                push_entry.parse_valid = 1'b1;
                push_entry.parse_code  = (q < ip_total_len_reg && !sticky_reg[1])
                                         ? FC_IPPAYLOAD : FC_OTHER;
                push_entry.parse_val   = VAL_W'(old_byte);
            end

            for (int i = 0; i < CRC_BYTES - 1; i++) begin
                delay_next[i] = delay_reg[i+1];
            end
            delay_next[CRC_BYTES-1] = s_data_byte;
        end else begin
            delay_next[byte_count_reg[CRC_IDX_W-1:0]] = s_data_byte;
        end

        if (byte_count_reg == LEN_MAX) begin
            sticky_pp[0] = 1'b1;
        end else begin
            bc_pp = byte_count_reg + LEN_W'(1);
        end

        // fcs, short frames give what arrived
        fill = (bc_pp < LEN_W'(CRC_BYTES)) ? bc_pp : LEN_W'(CRC_BYTES);
        crc  = '0;
        for (int i = 0; i < CRC_BYTES; i++) begin
            if (LEN_W'(i) < fill) begin
                crc = {crc[CRC_W-9:0], delay_next[i]};
            end
        end

        // frame status
        hdr_pp = vlan_pp ? ETH_HDR_VLAN : ETH_HDR_BASE;
        hl_pp  = (hw_pp < 4'd5) ? IP_HDR_MIN : LEN_W'({hw_pp, 2'b00});
        pl     = bc_pp - LEN_W'(CRC_BYTES) - hdr_pp;
        if (sticky_pp[0] || bc_pp > max_len_reg) begin
            status = ST_LONG;
        end else if (bc_pp < min_len_reg) begin
            status = ST_SHORT;
        end else if (bc_pp < hdr_pp + LEN_W'(CRC_BYTES)) begin
            status = ST_TRUNC;
        end else if (!ipv4_pp) begin
            status = ST_NONIP_OK;
        end else if (pl < hl_pp) begin
            status = ST_TRUNC;
        end else if (sticky_pp[1]) begin
            status = ST_BADLEN;
        end else if (pl < iptl_pp) begin
            status = ST_TRUNC;
        end else begin
            status = ST_IPV4_OK;
        end

        push_entry.frame_end = s_frame_end;
        push_entry.crc       = crc;
        push_entry.status    = status;

        if (s_frame_end) begin
            byte_count_next   = '0;
            has_vlan_next     = 1'b0;
            is_ipv4_next      = 1'b0;
            header_words_next = '0;
            ip_total_len_next = '0;
            sticky_next       = '0;
        end else begin
            byte_count_next   = bc_pp;
            has_vlan_next     = vlan_pp;
            is_ipv4_next      = ipv4_pp;
            header_words_next = hw_pp;
            ip_total_len_next = iptl_pp;
            sticky_next       = sticky_pp;
        end
    end

    assign push = accept && (push_entry.parse_valid || s_frame_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg      <= MIN_LEN_RST;
            max_len_reg      <= MAX_LEN_RST;
            byte_count_reg   <= '0;
            has_vlan_reg     <= 1'b0;
            is_ipv4_reg      <= 1'b0;
            header_words_reg <= '0;
            ip_total_len_reg <= '0;
            sticky_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MIN_FRAME_LEN: min_len_reg <= cfg_data;
                    REG_MAX_FRAME_LEN: max_len_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                byte_count_reg   <= byte_count_next;
                has_vlan_reg     <= has_vlan_next;
                is_ipv4_reg      <= is_ipv4_next;
                header_words_reg <= header_words_next;
                ip_total_len_reg <= ip_total_len_next;
                sticky_reg       <= sticky_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            acc_reg   <= acc_next;
            delay_reg <= delay_next;
        end
    end

endmodule

[hdl/eiphp_queue.sv]
// ----------------------------------------------------------------------------
// eiphp_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module eiphp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  eiphp_pkg::fr_entry_t push_entry,
    input  logic                 pop,
    output eiphp_pkg::fr_entry_t head,
    output logic                 empty,
    output logic                 full
);
    import eiphp_pkg::*;

    fr_entry_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [FIFO_AW:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !full && !pop) |=> (count_reg == $past(count_reg) + (FIFO_AW+1)'(1)))
        else $error("queue push lost");

endmodule

[hdl/eiphp_back.sv]
// ----------------------------------------------------------------------------
// eiphp_back
// expands each queued request into result items behind an output register
// ----------------------------------------------------------------------------
module eiphp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  eiphp_pkg::fr_entry_t           head,
    input  logic                           empty,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [4:0]                     m_field_code,
    output logic [eiphp_pkg::VAL_W-1:0]    m_field_value,
    output logic                           m_frame_done
);
    import eiphp_pkg::*;

    // result slots: parsed field, fragment offset, fcs, status
    logic [3:0]         mask, remaining, pick;
    logic [3:0]         sent_reg, sent_next;
    logic               load;
    logic               m_valid_reg, m_valid_next;
    field_code_t        code_reg, code_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic               done_reg, done_next;

    assign mask      = {head.frame_end, head.frame_end,
                        head.parse_valid && head.parse_split, head.parse_valid};
    assign remaining = mask & ~sent_reg;
    assign pick      = remaining & (~remaining + 4'd1);
    assign load      = !empty && (!m_valid_reg || m_ready);
    assign pop       = load && (remaining == pick);

    always_comb begin
        code_next    = code_reg;
        value_next   = value_reg;
        done_next    = done_reg;
        sent_next    = sent_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next = 1'b1;
            done_next    = 1'b0;
            sent_next    = pop ? 4'd0 : (sent_reg | pick);
            if (pick[0]) begin
                code_next  = head.parse_code;
                value_next = head.parse_split ? VAL_W'(head.parse_val[15:13])
                                              : head.parse_val;
            end else if (pick[1]) begin
                code_next  = FC_FRAGOFF;
                value_next = VAL_W'(head.parse_val[12:0] & FRAG_MASK);
            end else if (pick[2]) begin
                code_next  = FC_CRC;
                value_next = VAL_W'(head.crc);
            end else begin
                code_next  = FC_STATUS;
                value_next = VAL_W'(head.status);
                done_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sent_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            sent_reg    <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        value_reg <= value_next;
        done_reg  <= done_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_field_code  = code_reg;
    assign m_field_value = value_reg;
    assign m_frame_done  = done_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && done_reg) |-> (code_reg == FC_STATUS))
        else $error("frame done on a non-status result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> (sent_reg == 4'd0))
        else $error("stale slot marks with empty queue");

endmodule

[hdl/ethernet_ipv4_header_parser.sv]
// a request is queued, then the back stage moves its first result into the output register
// throughput: one byte per cycle in while the queue is not full; one result per cycle out
// while m_ready is high; bytes with two to four results (flags/offset, frame end)
// give them in turn, and a four-entry request queue lets the input run on meanwhile
// reset: synchronous active low; length limits return to 64 and 1522, frame state
// is cleared and the queue and output register are emptied
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser
// ethernet ii / vlan / ipv4 header parser with fcs split-off and frame status
// ----------------------------------------------------------------------------
module ethernet_ipv4_header_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [eiphp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eiphp_pkg::CFG_W-1:0]      cfg_data,
    // frame bytes in
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_frame_end,
    // tagged results out
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [4:0]                       m_field_code,
    output logic [eiphp_pkg::VAL_W-1:0]      m_field_value,
    output logic                             m_frame_done
);
    import eiphp_pkg::*;

    // front to queue
    logic      push;
    fr_entry_t push_entry;
    logic      q_full;
    // queue to back
    fr_entry_t head;
    logic      q_empty;
    logic      pop;

    // front: four-byte fcs delay line, header position counter, field
    // classification and end-of-frame status; one request per byte that
    // yields anything
    eiphp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // request queue decouples the byte stream from result delivery
    eiphp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // back: walks the slots of the head request, one result per cycle while m_ready is high
    eiphp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_code  (m_field_code),
        .m_field_value (m_field_value),
        .m_frame_done  (m_frame_done)
    );

endmodule

[dv/eiphp_field_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eiphp_field_checker
// watches the byte and result channels of the header parser, works out the
// tagged fields each accepted byte should produce and compares them in order
// ----------------------------------------------------------------------------
module eiphp_field_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [eiphp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eiphp_pkg::CFG_W-1:0]      cfg_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_frame_end,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [4:0]                       m_field_code,
    input  logic [eiphp_pkg::VAL_W-1:0]      m_field_value,
    input  logic                             m_frame_done,
    output int                               mismatch_count,
    output int                               pending_fields
);
    import eiphp_pkg::*;

    localparam int IHL_MIN = IP_HDR_MIN / 4;

    typedef struct packed {
        field_code_t      code;
        logic [VAL_W-1:0] value;
        logic             done;
    } parsed_field_t;

    parsed_field_t    parsed_fields_q[$];

    logic [CFG_W-1:0] min_len;
    logic [CFG_W-1:0] max_len;
    int unsigned      byte_cnt;
    logic [VAL_W-1:0] acc;
    logic             vlan_seen;
    logic             ipv4_seen;
    logic [3:0]       ihl;
    logic [15:0]      total_len;
    logic [7:0]       fcs_line [CRC_BYTES];
    logic             len_overflow;
    logic             ip_len_bad;

    task automatic clear_frame();
        byte_cnt     = 0;
        acc          = '0;
        vlan_seen    = 1'b0;
        ipv4_seen    = 1'b0;
        ihl          = '0;
        total_len    = '0;
        len_overflow = 1'b0;
        ip_len_bad   = 1'b0;
        for (int i = 0; i < CRC_BYTES; i++) fcs_line[i] = '0;
    endtask

    task automatic push_field(input field_code_t c, input logic [VAL_W-1:0] v,
                              input logic d);
        parsed_field_t f;
        f.code  = c;
        f.value = v;
        f.done  = d;
        parsed_fields_q.push_back(f);
    endtask

    function automatic int unsigned ip_hdr_bytes();
        return (ihl < IHL_MIN) ? int'(IP_HDR_MIN) : 4 * int'(ihl);
    endfunction

    // one byte leaving the fcs delay line, p is its offset in the frame
    task automatic parse_wire_byte(input logic [7:0] b, input int unsigned p);
        int unsigned      eth_len;
        int unsigned      ip_len;
        int unsigned      q;
        logic [VAL_W-1:0] w;
        acc     = {acc[VAL_W-9:0], b};
        w       = acc;
        eth_len = vlan_seen ? ETH_HDR_VLAN : ETH_HDR_BASE;
        ip_len  = ip_hdr_bytes();
        if (p < ETH_HDR_BASE) begin
            if (p == 5) begin
                push_field(FC_DST, w, 1'b0);
            end else if (p == 11) begin
                push_field(FC_SRC, w, 1'b0);
            end else if (p == 13) begin
                vlan_seen = (w[15:0] == ETYPE_VLAN);
                push_field(FC_TYPE, VAL_W'(w[15:0]), 1'b0);
            end
        end else if (p < eth_len) begin
            if (p == 17) push_field(FC_VLAN, VAL_W'(w[31:0]), 1'b0);
        end else begin
            q = p - eth_len;
            if (q == 0) begin
                ipv4_seen = ((b & VER_MASK) == VER_IPV4);
                ihl       = b[3:0];
                if (!ipv4_seen) push_field(FC_OTHER, VAL_W'(b), 1'b0);
                else if (ihl < IHL_MIN) ip_len_bad = 1'b1;
            end else if (!ipv4_seen) begin
                push_field(FC_OTHER, VAL_W'(b), 1'b0);
            end else if (q < IP_HDR_MIN) begin
                case (q)
                    1: push_field(FC_DSCP, VAL_W'(b), 1'b0);
                    3: begin
                        total_len = w[15:0];
                        if (total_len < ip_len) ip_len_bad = 1'b1;
                    end
                    5: push_field(FC_ID, VAL_W'(w[15:0]), 1'b0);
                    7: begin
                        push_field(FC_FLAGS, VAL_W'(w[15:13]), 1'b0);
                        push_field(FC_FRAGOFF, VAL_W'(w[12:0] & FRAG_MASK), 1'b0);
                    end
                    8:  push_field(FC_TTL, VAL_W'(b), 1'b0);
                    9:  push_field(FC_PROTO, VAL_W'(b), 1'b0);
                    11: push_field(FC_CKSUM, VAL_W'(w[15:0]), 1'b0);
                    15: push_field(FC_IPSRC, VAL_W'(w[31:0]), 1'b0);
                    19: push_field(FC_IPDST, VAL_W'(w[31:0]), 1'b0);
                    default: ;
                endcase
            end else if (q < ip_len) begin
                if (q[1:0] == 2'b11) push_field(FC_OPTION, VAL_W'(w[31:0]), 1'b0);
            end else begin
                push_field((q < total_len && !ip_len_bad) ? FC_IPPAYLOAD : FC_OTHER,
                           VAL_W'(b), 1'b0);
            end
        end
    endtask

    function automatic frame_status_t frame_verdict();
        int unsigned   eth_len;
        int unsigned   body;
        frame_status_t st;
        eth_len = vlan_seen ? ETH_HDR_VLAN : ETH_HDR_BASE;
        if (len_overflow || byte_cnt > max_len) begin
            st = ST_LONG;
        end else if (byte_cnt < min_len) begin
            st = ST_SHORT;
        end else if (byte_cnt < eth_len + CRC_BYTES) begin
            st = ST_TRUNC;
        end else if (!ipv4_seen) begin
            st = ST_NONIP_OK;
        end else begin
            body = byte_cnt - CRC_BYTES - eth_len;
            if (body < ip_hdr_bytes()) st = ST_TRUNC;
            else if (ip_len_bad) st = ST_BADLEN;
            else if (body < total_len) st = ST_TRUNC;
            else st = ST_IPV4_OK;
        end
        return st;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic last);
        logic [7:0]       oldest;
        logic [CRC_W-1:0] fcs;
        int unsigned      fill;
        if (byte_cnt >= CRC_BYTES) begin
            oldest = fcs_line[0];
            for (int i = 0; i < CRC_BYTES - 1; i++) fcs_line[i] = fcs_line[i+1];
            fcs_line[CRC_BYTES-1] = b;
            parse_wire_byte(oldest, byte_cnt - CRC_BYTES);
        end else begin
            fcs_line[byte_cnt] = b;
        end
        if (byte_cnt >= LEN_MAX) len_overflow = 1'b1;
        else byte_cnt++;
        if (last) begin
            fill = (byte_cnt < CRC_BYTES) ? byte_cnt : CRC_BYTES;
            fcs  = '0;
            for (int i = 0; i < fill; i++) fcs = {fcs[CRC_W-9:0], fcs_line[i]};
            push_field(FC_CRC, VAL_W'(fcs), 1'b0);
            push_field(FC_STATUS, VAL_W'(frame_verdict()), 1'b1);
            clear_frame();
        end
    endtask

    always @(posedge aclk) begin
        parsed_field_t want;
        if (!aresetn) begin
            min_len = MIN_LEN_RST;
            max_len = MAX_LEN_RST;
            clear_frame();
            parsed_fields_q.delete();
            mismatch_count = 0;
            pending_fields <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (parsed_fields_q.size() == 0) begin
                    $display("%0t: unexpected result code %0d value %0h", $time,
                             m_field_code, m_field_value);
                    mismatch_count++;
                end else begin
                    want = parsed_fields_q.pop_front();
                    if (m_field_code !== want.code) begin
                        $display("%0t: field_code expected %0d actual %0d", $time,
                                 want.code, m_field_code);
                        mismatch_count++;
                    end
                    if (m_field_value !== want.value) begin
                        $display("%0t: field_value (code %0d) expected %0h actual %0h",
                                 $time, want.code, want.value, m_field_value);
                        mismatch_count++;
                    end
                    if (m_frame_done !== want.done) begin
                        $display("%0t: frame_done (code %0d) expected %0b actual %0b",
                                 $time, want.code, want.done, m_frame_done);
                        mismatch_count++;
                    end
                end
            end
            // a byte taken at this edge still sees the limits from before it
            if (s_valid && s_ready) take_byte(s_data_byte, s_frame_end);
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MIN_FRAME_LEN: min_len = cfg_data;
                    REG_MAX_FRAME_LEN: max_len = cfg_data;
                    default: ;
                endcase
            end
            pending_fields <= parsed_fields_q.size();
        end
    end

endmodule

[dv/tb_ethernet_ipv4_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ethernet_ipv4_header_parser
// drives whole frames byte by byte into the parser under several length
// limit settings: directed frames for the header and status cases, then
// random well-formed, broken and noise frames; a separate checker predicts
// and compares results
// ----------------------------------------------------------------------------
module tb_ethernet_ipv4_header_parser;
    import eiphp_pkg::*;

    localparam int IDLE_PCT       = 26;     // chance of a gap per cycle, each side
    localparam int HOLD_CYCLES    = 80;     // receiver back-pressure stretch
    localparam int SETTLE_CYCLES  = 12;     // output reg plus four-entry queue, with margin
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no request moving
    localparam int RANDOM_SHARE   = 40;     // random bytes at the end
    localparam int IHL_MIN        = IP_HDR_MIN / 4;
    localparam int IHL_MAX        = 15;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte   = '0;
    logic                   s_frame_end   = 1'b0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [4:0]             m_field_code;
    logic [VAL_W-1:0]       m_field_value;
    logic                   m_frame_done;

    int                     mismatch_count;
    int                     pending_fields;

    // stimulus -> receiver controls
    logic                   steady        = 1'b0;   // no gaps on either side
    logic                   hold_go       = 1'b0;   // start a receiver hold-off

    int                     hold_left     = 0;
    int                     quiet_cycles  = 0;
    int                     bytes_sent    = 0;
    logic [7:0]             frame_bytes[$];

    ethernet_ipv4_header_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_code  (m_field_code),
        .m_field_value (m_field_value),
        .m_frame_done  (m_frame_done)
    );

    eiphp_field_checker field_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_field_code   (m_field_code),
        .m_field_value  (m_field_value),
        .m_frame_done   (m_frame_done),
        .mismatch_count (mismatch_count),
        .pending_fields (pending_fields)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // result side: random stalls, or a counted hold-off when asked for
    always @(posedge aclk) begin
        if (hold_go) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: give up if no request moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_ethernet_ipv4_header_parser: errors");
            $finish;
        end
    end

    // one byte request; valid stays up until the parser takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_frame_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic trim_frame(input int keep);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    endtask

    // dst, src and either a plain ethertype or 0x8100 plus the tag word
    task automatic add_eth(input logic tagged_hdr);
        logic [15:0] etype;
        add_random(12);
        etype = 16'($urandom);
        if (tagged_hdr) etype = ETYPE_VLAN;
        else if (etype == ETYPE_VLAN) etype = ~etype;
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        if (tagged_hdr) add_random(4);
    endtask

    // version/ihl, dscp, total length, then random id..dst and options
    task automatic add_ipv4(input int ihl, input logic [15:0] tot_len);
        frame_bytes.push_back(VER_IPV4 | 8'(ihl));
        add_random(1);
        frame_bytes.push_back(tot_len[15:8]);
        frame_bytes.push_back(tot_len[7:0]);
        add_random(int'(IP_HDR_MIN) - 4);
        if (ihl > IHL_MIN) add_random(4 * ihl - int'(IP_HDR_MIN));
    endtask

    // first payload byte with a version nibble other than 4
    task automatic add_non_ip_start();
        logic [7:0] b;
        b = 8'($urandom);
        if ((b & VER_MASK) == VER_IPV4) b = b ^ 8'h80;
        frame_bytes.push_back(b);
    endtask

    // non-ip frame of an exact length, fcs included
    task automatic send_non_ip(input int len, input logic tagged_hdr);
        add_eth(tagged_hdr);
        add_non_ip_start();
        add_random(len - frame_bytes.size() - CRC_BYTES);
        add_random(CRC_BYTES);
        send_frame();
    endtask

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic send_random_frame();
        int kind;
        int ihl;
        int pay;
        kind = $urandom_range(99);
        add_eth($urandom_range(2) == 0);
        if (kind < 60) begin
            ihl = ($urandom_range(9) == 0) ? IHL_MAX : IHL_MIN + $urandom_range(2);
            pay = $urandom_range(8);
            add_ipv4(ihl, 16'(4 * ihl + pay));
            add_random(pay + $urandom_range(3));    // payload plus some padding
        end else if (kind < 75) begin
            ihl = $urandom_range(IHL_MAX);
            add_ipv4(ihl, ($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(72)));
            add_random($urandom_range(10));
        end else if (kind < 90) begin
            add_non_ip_start();
            add_random($urandom_range(12));
        end
        add_random(CRC_BYTES);
        // noise frames and a few others get cut anywhere
        if (kind >= 90 || $urandom_range(9) == 0)
            trim_frame($urandom_range(frame_bytes.size(), 1));
        send_frame();
    endtask

    task automatic random_traffic();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_SHARE) send_random_frame();
    endtask

    // drop valid, wait until every expected result is out, then let the
    // pipeline settle in case the last bytes were still being worked on
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_fields != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both limits back to back, optionally a write to an unused index
    task automatic set_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                              input logic poke_spare, input logic [CFG_IDX_W-1:0] spare);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MIN_FRAME_LEN;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_index <= REG_MAX_FRAME_LEN;
        cfg_data  <= hi;
        @(posedge aclk);
        if (poke_spare) begin
            cfg_index <= spare;
            cfg_data  <= ~lo;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- reset limits 64 / 1522 ----
        // tagged ipv4 frame with options, payload and padding while the
        // receiver holds off: queue fills, input stalls
        s_valid <= 1'b0;
        hold_go <= 1'b1;
        steady  <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        add_eth(1'b1);
        add_ipv4(IHL_MIN + 2, 16'd30);
        add_random(14);
        add_random(CRC_BYTES);
        send_frame();
        steady <= 1'b0;
        wait_idle();

        // ---- widest limits; unused index write must be ignored ----
        set_limits('0, '1, 1'b1, REG_SPARE_LO);

        // ihl below five: header taken as 20 bytes, bad length
        add_eth(1'b0);
        add_ipv4(3, 16'd40);
        add_random(CRC_BYTES);
        send_frame();

        // total length below the header length
        add_eth(1'b0);
        add_ipv4(IHL_MIN + 1, 16'd10);
        add_random(CRC_BYTES);
        send_frame();

        // ethernet header cut short, then a frame that is only fcs
        add_random(6 + CRC_BYTES);
        send_frame();
        add_random(CRC_BYTES);
        send_frame();
        wait_idle();

        // ---- minimum above maximum: everything is long ----
        // frames shorter than the fcs: partial crc
        set_limits('1, '0, 1'b1, REG_SPARE_HI);
        add_random(1);
        send_frame();
        add_random(3);
        send_frame();
        wait_idle();

        // ---- narrow window: under the minimum, tagged non-ip, then random ----
        set_limits(16'd20, 16'd48, 1'b0, REG_SPARE_LO);
        send_non_ip(19, 1'b0);
        send_non_ip(24, 1'b1);
        random_traffic();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("tb_ethernet_ipv4_header_parser: clean");
        end else begin
            $display("tb_ethernet_ipv4_header_parser: errors");
        end
        $finish;
    end

endmodule

[files.f]
hdl/eiphp_pkg.sv
hdl/eiphp_front.sv
hdl/eiphp_queue.sv
hdl/eiphp_back.sv
hdl/ethernet_ipv4_header_parser.sv
dv/eiphp_field_checker.sv
dv/tb_ethernet_ipv4_header_parser.sv
